// File: rtl/core/pte_pkg.sv
// Shared constants and types for the prefix trie engine.
// No dependencies; used by prefix_trie_engine.sv and the testbench.
package pte_pkg;

    localparam int NODE_COUNT    = 256;
    localparam int ALPHABET_SIZE = 26;

    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int USED_W     = NODE_W + 1;
    localparam int SLOT_COUNT = NODE_COUNT * ALPHABET_SIZE;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int CMD_W      = 2;
    localparam int LETTER_W   = 5;

    // command codes; anything other than insert or search acts as a prefix test
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PREFIX = 2'd2;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_EMIT
    } state_t;

endpackage

// File: rtl/core/prefix_trie_engine.sv
// Prefix trie engine: insert, search and prefix test, one trie level per letter.
// Each letter is accepted in ST_IDLE, which issues the child-table read, and is worked in
// ST_LOOK, which writes back a new child on insert; a final letter then passes ST_EMIT,
// which registers the result onto out_valid once the output is free. Letters are only taken in ST_IDLE.
// After reset a clearing pass over all SLOT_COUNT (6656) child slots zeroes the child table
// and end marks; in_ready stays low until it ends. Depends on pte_pkg, pte_ram.
module prefix_trie_engine (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [pte_pkg::CMD_W-1:0]    command,
    input  logic [pte_pkg::LETTER_W-1:0] letter,
    input  logic                         last_letter,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         hit,
    output logic                         status
);

    pte_pkg::state_t state_reg, state_next;

    logic [pte_pkg::SLOT_W-1:0]   clr_reg, clr_next;
    logic [pte_pkg::NODE_W-1:0]   node_reg, node_next;
    logic                         missing_reg, missing_next;
    logic                         ovf_reg, ovf_next;
    logic [pte_pkg::USED_W-1:0]   used_reg, used_next;
    logic                         out_valid_reg, out_valid_next;

    logic [pte_pkg::CMD_W-1:0]    cmd_reg, cmd_next;
    logic [pte_pkg::LETTER_W-1:0] letter_reg, letter_next;
    logic                         last_reg, last_next;
    logic [pte_pkg::SLOT_W-1:0]   slot_reg, slot_next;
    logic                         res_broken_reg, res_broken_next;
    logic                         res_status_reg, res_status_next;
    logic                         hit_reg, hit_next;
    logic                         status_reg, status_next;

    logic                         child_we, child_re;
    logic [pte_pkg::SLOT_W-1:0]   child_waddr, child_raddr;
    logic [pte_pkg::NODE_W-1:0]   child_wdata, child_rdata;
    logic                         mark_we, mark_re;
    logic [pte_pkg::NODE_W-1:0]   mark_waddr, mark_raddr;
    logic [0:0]                   mark_wdata, mark_rdata;

    logic                         accept;
    logic                         letter_ok_in;
    logic [pte_pkg::SLOT_W-1:0]   slot_in;
    logic                         broken;
    logic                         letter_ok;
    logic [pte_pkg::NODE_W-1:0]   node_n;
    logic                         miss_n;
    logic                         ovf_n;

    assign in_ready  = (state_reg == pte_pkg::ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign status    = status_reg;

    assign letter_ok_in = (letter < pte_pkg::LETTER_W'(pte_pkg::ALPHABET_SIZE));
    assign slot_in = letter_ok_in ?
        (pte_pkg::SLOT_W'(node_reg) * pte_pkg::SLOT_W'(pte_pkg::ALPHABET_SIZE)
         + pte_pkg::SLOT_W'(letter)) : '0;

    assign broken    = missing_reg || ovf_reg;
    assign letter_ok = (letter_reg < pte_pkg::LETTER_W'(pte_pkg::ALPHABET_SIZE));

    pte_ram #(
        .WIDTH (pte_pkg::NODE_W),
        .DEPTH (pte_pkg::SLOT_COUNT)
    ) u_child_ram (
        .clk   (clk),
        .we    (child_we),
        .waddr (child_waddr),
        .wdata (child_wdata),
        .re    (child_re),
        .raddr (child_raddr),
        .rdata (child_rdata)
    );

    pte_ram #(
        .WIDTH (1),
        .DEPTH (pte_pkg::NODE_COUNT)
    ) u_mark_ram (
        .clk   (clk),
        .we    (mark_we),
        .waddr (mark_waddr),
        .wdata (mark_wdata),
        .re    (mark_re),
        .raddr (mark_raddr),
        .rdata (mark_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pte_pkg::ST_CLEAR;
            clr_reg       <= '0;
            node_reg      <= '0;
            missing_reg   <= 1'b0;
            ovf_reg       <= 1'b0;
            used_reg      <= pte_pkg::USED_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            node_reg      <= node_next;
            missing_reg   <= missing_next;
            ovf_reg       <= ovf_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        letter_reg     <= letter_next;
        last_reg       <= last_next;
        slot_reg       <= slot_next;
        res_broken_reg <= res_broken_next;
        res_status_reg <= res_status_next;
        hit_reg        <= hit_next;
        status_reg     <= status_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        node_next       = node_reg;
        missing_next    = missing_reg;
        ovf_next        = ovf_reg;
        used_next       = used_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        cmd_next        = cmd_reg;
        letter_next     = letter_reg;
        last_next       = last_reg;
        slot_next       = slot_reg;
        res_broken_next = res_broken_reg;
        res_status_next = res_status_reg;
        hit_next        = hit_reg;
        status_next     = status_reg;

        child_we    = 1'b0;
        child_waddr = slot_reg;
        child_wdata = '0;
        child_re    = 1'b0;
        child_raddr = slot_in;
        mark_we     = 1'b0;
        mark_waddr  = '0;
        mark_wdata  = 1'b0;
        mark_re     = 1'b0;
        mark_raddr  = '0;

        node_n = node_reg;
        miss_n = missing_reg;
        ovf_n  = ovf_reg;

        case (state_reg)
            pte_pkg::ST_CLEAR:
            begin
                child_we    = 1'b1;
                child_waddr = clr_reg;
                child_wdata = '0;
                mark_we     = 1'b1;
                mark_waddr  = clr_reg[pte_pkg::NODE_W-1:0];
                mark_wdata  = 1'b0;
                clr_next    = clr_reg + 1'b1;
                if (clr_reg == pte_pkg::SLOT_W'(pte_pkg::SLOT_COUNT - 1))
                begin
                    state_next = pte_pkg::ST_IDLE;
                end
            end

            pte_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    child_re    = letter_ok_in;
                    cmd_next    = command;
                    letter_next = letter;
                    last_next   = last_letter;
                    slot_next   = slot_in;
                    state_next  = pte_pkg::ST_LOOK;
                end
            end

            pte_pkg::ST_LOOK:
            begin
                // a broken walk sits still until the final letter
                if (!broken)
                begin
                    if (!letter_ok)
                    begin
                        if (cmd_reg != pte_pkg::CMD_INSERT)
                        begin
                            miss_n = 1'b1;
                        end
                    end
                    else if (cmd_reg == pte_pkg::CMD_INSERT)
                    begin
                        if (child_rdata == '0)
                        begin
                            if (used_reg < pte_pkg::USED_W'(pte_pkg::NODE_COUNT))
                            begin
                                child_we    = 1'b1;
                                child_wdata = used_reg[pte_pkg::NODE_W-1:0];
                                node_n      = used_reg[pte_pkg::NODE_W-1:0];
                                used_next   = used_reg + 1'b1;
                            end
                            else
                            begin
                                ovf_n = 1'b1;
                            end
                        end
                        else
                        begin
                            node_n = child_rdata;
                        end
                    end
                    else if (child_rdata == '0)
                    begin
                        miss_n = 1'b1;
                    end
                    else
                    begin
                        node_n = child_rdata;
                    end
                end

                if (last_reg)
                begin
                    if ((cmd_reg == pte_pkg::CMD_INSERT) && !ovf_n && !miss_n)
                    begin
                        mark_we    = 1'b1;
                        mark_waddr = node_n;
                        mark_wdata = 1'b1;
                    end
                    mark_re         = 1'b1;
                    mark_raddr      = node_n;
                    res_broken_next = miss_n || ovf_n;
                    res_status_next = (cmd_reg == pte_pkg::CMD_INSERT) && ovf_n;
                    node_next       = '0;
                    missing_next    = 1'b0;
                    ovf_next        = 1'b0;
                    state_next      = pte_pkg::ST_EMIT;
                end
                else
                begin
                    node_next    = node_n;
                    missing_next = miss_n;
                    ovf_next     = ovf_n;
                    state_next   = pte_pkg::ST_IDLE;
                end
            end

            pte_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    case (cmd_reg)
                        pte_pkg::CMD_INSERT: hit_next = 1'b0;
                        pte_pkg::CMD_SEARCH: hit_next = !res_broken_reg && mark_rdata[0];
                        default:             hit_next = !res_broken_reg;
                    endcase
                    state_next = pte_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = pte_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_rise_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == pte_pkg::ST_EMIT))
        else $error("result raised outside the emit step");

    a_used_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (used_reg != '0) && (used_reg <= pte_pkg::USED_W'(pte_pkg::NODE_COUNT)))
        else $error("node pool count out of range");

    a_status_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(hit_reg && status_reg))
        else $error("pool-full result carries a hit");

    a_look_exits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pte_pkg::ST_LOOK) |=>
            ((state_reg == pte_pkg::ST_IDLE) || (state_reg == pte_pkg::ST_EMIT)))
        else $error("lookup step did not complete in one cycle");

    a_walk_reset_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pte_pkg::ST_EMIT) |-> ((node_reg == '0) && !missing_reg && !ovf_reg))
        else $error("walk not returned to root after final letter");
`endif

endmodule

// File: rtl/core/pte_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module pte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AddrW-1:0] waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AddrW-1:0] raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: dv/prefix_trie_engine_tb.sv
// Self-checking testbench for prefix_trie_engine: directed words, then random word streams.
// Results are checked against a bench trie model or pinned values. Depends on pte_pkg and the RTL.
module prefix_trie_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pte_pkg::*;

    // the spare command code behaves as a prefix test
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam int RANDOM_LETTERS = 600;
    localparam int LONG_HOLD      = 400;
    localparam int HOLD_AT_RESULT = 40;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int MAX_WORD       = 12;

    typedef struct packed {
        logic hit;
        logic status;
    } answer_t;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [LETTER_W-1:0] ltr;
        logic                fin;
        logic                pin;
        logic                hit;
        logic                status;
    } stim_row_t;

    typedef struct packed {
        logic [3:0]                         len;
        logic [MAX_WORD-1:0][LETTER_W-1:0]  ch;
    } word_t;

    localparam int DIRECTED_ROWS = 25;
    localparam stim_row_t DIRECTED[DIRECTED_ROWS] = '{
        '{CMD_SEARCH, 5'd0,  1'b1, 1'b1, 1'b0, 1'b0},   // empty trie
        '{CMD_PREFIX, 5'd25, 1'b1, 1'b1, 1'b0, 1'b0},
        '{CMD_INSERT, 5'd0,  1'b0, 1'b0, 1'b0, 1'b0},   // insert "ab"
        '{CMD_INSERT, 5'd1,  1'b1, 1'b1, 1'b0, 1'b0},
        '{CMD_SEARCH, 5'd0,  1'b0, 1'b0, 1'b0, 1'b0},
        '{CMD_SEARCH, 5'd1,  1'b1, 1'b1, 1'b1, 1'b0},
        '{CMD_SEARCH, 5'd0,  1'b1, 1'b1, 1'b0, 1'b0},   // "a" is a path, not a word
        '{CMD_PREFIX, 5'd0,  1'b1, 1'b1, 1'b1, 1'b0},
        '{CMD_SPARE,  5'd0,  1'b0, 1'b0, 1'b0, 1'b0},
        '{CMD_SPARE,  5'd1,  1'b1, 1'b1, 1'b1, 1'b0},
        '{CMD_INSERT, 5'd25, 1'b0, 1'b0, 1'b0, 1'b0},   // out of range letter skipped on insert
        '{CMD_INSERT, 5'd31, 1'b0, 1'b0, 1'b0, 1'b0},
        '{CMD_INSERT, 5'd25, 1'b1, 1'b0, 1'b0, 1'b0},
        '{CMD_SEARCH, 5'd25, 1'b0, 1'b0, 1'b0, 1'b0},
        '{CMD_SEARCH, 5'd25, 1'b1, 1'b0, 1'b0, 1'b0},
        '{CMD_SEARCH, 5'd31, 1'b1, 1'b1, 1'b0, 1'b0},
        '{CMD_PREFIX, 5'd26, 1'b1, 1'b1, 1'b0, 1'b0},
        '{CMD_INSERT, 5'd0,  1'b0, 1'b0, 1'b0, 1'b0},   // mixed commands in one word
        '{CMD_SEARCH, 5'd1,  1'b1, 1'b0, 1'b0, 1'b0},
        '{CMD_PREFIX, 5'd5,  1'b0, 1'b0, 1'b0, 1'b0},   // broken walk, then insert
        '{CMD_INSERT, 5'd0,  1'b1, 1'b0, 1'b0, 1'b0},
        '{CMD_INSERT, 5'd30, 1'b1, 1'b1, 1'b0, 1'b0},   // marks the root
        '{CMD_SEARCH, 5'd16, 1'b1, 1'b1, 1'b0, 1'b0},
        '{CMD_PREFIX, 5'd0,  1'b0, 1'b0, 1'b0, 1'b0},
        '{CMD_SPARE,  5'd1,  1'b1, 1'b0, 1'b0, 1'b0}
    };

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [CMD_W-1:0]    command;
    logic [LETTER_W-1:0] letter;
    logic                last_letter;
    logic                out_valid;
    logic                out_ready;
    logic                hit;
    logic                status;

    // typed-in expectation travelling with the current letter
    logic pin_now, pin_hit, pin_status;

    // trie model
    logic [NODE_W-1:0] trie_child [SLOT_COUNT];
    logic              trie_mark  [NODE_COUNT];
    logic [NODE_W-1:0] walk_node;
    logic              walk_missing;
    logic              walk_full;
    logic [USED_W-1:0] used_nodes;

    answer_t answers_due[$];
    answer_t answer_head;
    word_t   vocab[$];
    int      fails = 0;
    int      letters_sent = 0;
    int      cycle_count = 0;
    bit      sender_calm = 1'b0;
    bit      receiver_calm = 1'b0;

    prefix_trie_engine dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .letter      (letter),
        .last_letter (last_letter),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .hit         (hit),
        .status      (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic trie_clear();
        for (int i = 0; i < SLOT_COUNT; i++)
            trie_child[i] = '0;
        for (int i = 0; i < NODE_COUNT; i++)
            trie_mark[i] = 1'b0;
        walk_node    = '0;
        walk_missing = 1'b0;
        walk_full    = 1'b0;
        used_nodes   = USED_W'(1);
    endtask

    // one trie level per letter; queues the answer on the final letter
    task automatic trie_walk(input logic [CMD_W-1:0] cmd, input logic [LETTER_W-1:0] ltr,
                             input logic fin);
        int                slot;
        logic [NODE_W-1:0] nxt;
        answer_t           ans;
        if (!(walk_missing || walk_full))
        begin
            if (int'(ltr) >= ALPHABET_SIZE)
            begin
                if (cmd != CMD_INSERT)
                    walk_missing = 1'b1;
            end
            else
            begin
                slot = int'(walk_node) * ALPHABET_SIZE + int'(ltr);
                nxt  = trie_child[slot];
                if (cmd == CMD_INSERT)
                begin
                    if (nxt == '0)
                    begin
                        if (int'(used_nodes) < NODE_COUNT)
                        begin
                            nxt = used_nodes[NODE_W-1:0];
                            used_nodes = used_nodes + 1'b1;
                            trie_child[slot] = nxt;
                        end
                        else
                            walk_full = 1'b1;
                    end
                    if (!walk_full)
                        walk_node = nxt;
                end
                else if (nxt == '0)
                    walk_missing = 1'b1;
                else
                    walk_node = nxt;
            end
        end
        if (fin)
        begin
            ans = '0;
            if (cmd == CMD_INSERT)
            begin
                if (walk_full)
                    ans.status = 1'b1;
                else if (!walk_missing)
                    trie_mark[walk_node] = 1'b1;
            end
            else if (cmd == CMD_SEARCH)
                ans.hit = !walk_missing && !walk_full && trie_mark[walk_node];
            else
                ans.hit = !(walk_missing || walk_full);
            if (pin_now)
            begin
                ans.hit    = pin_hit;
                ans.status = pin_status;
            end
            answers_due.push_back(ans);
            walk_node    = '0;
            walk_missing = 1'b0;
            walk_full    = 1'b0;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            trie_walk(command, letter, last_letter);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (answers_due.size() == 0)
            begin
                $error("unexpected result: hit=%0b status=%0b", hit, status);
                fails++;
            end
            else
            begin
                answer_head = answers_due.pop_front();
                if (hit !== answer_head.hit)
                begin
                    $error("hit: expected %0b, got %0b", answer_head.hit, hit);
                    fails++;
                end
                if (status !== answer_head.status)
                begin
                    $error("status: expected %0b, got %0b", answer_head.status, status);
                    fails++;
                end
            end
        end
    end

    // called and returns at a falling edge
    task automatic send_letter(input logic [CMD_W-1:0] c, input logic [LETTER_W-1:0] l,
                               input logic fin, input logic pin, input logic ph,
                               input logic ps);
        int gap;
        if ($urandom_range(0, 31) == 0)
            sender_calm = !sender_calm;
        gap = sender_calm ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        command     <= c;
        letter      <= l;
        last_letter <= fin;
        pin_now     <= pin;
        pin_hit     <= ph;
        pin_status  <= ps;
        in_valid    <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        letters_sent++;
        @(negedge clk);
    endtask

    function automatic logic [LETTER_W-1:0] draw_letter(input bit narrow);
        if ($urandom_range(0, 19) == 0)
            return LETTER_W'($urandom_range(ALPHABET_SIZE, 31));
        return narrow ? LETTER_W'($urandom_range(0, 3))
                      : LETTER_W'($urandom_range(0, ALPHABET_SIZE - 1));
    endfunction

    function automatic word_t draw_word(input int max_len);
        word_t w;
        bit    narrow;
        w      = '0;
        narrow = ($urandom_range(0, 2) == 0);
        w.len  = 4'($urandom_range(1, max_len));
        for (int k = 0; k < w.len; k++)
            w.ch[k] = draw_letter(narrow);
        return w;
    endfunction

    task automatic send_word(input word_t w, input logic [CMD_W-1:0] c, input bit scramble);
        logic [CMD_W-1:0] lc;
        for (int k = 0; k < w.len; k++)
        begin
            lc = scramble ? CMD_W'($urandom_range(0, 3)) : c;
            send_letter(lc, w.ch[k], k == w.len - 1, 1'b0, 1'b0, 1'b0);
        end
    endtask

    // receiver: random stall per result, one long hold so the engine backs up
    initial
    begin
        int stall;
        int taken;
        taken     = 0;
        out_ready = 1'b0;
        @(negedge clk);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                receiver_calm = !receiver_calm;
            if (taken == HOLD_AT_RESULT)
                stall = LONG_HOLD;
            else
                stall = receiver_calm ? 0 : $urandom_range(0, 8);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            taken++;
            @(negedge clk);
        end
    end

    initial
    begin
        word_t w;
        int    pick;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        command     = CMD_INSERT;
        letter      = '0;
        last_letter = 1'b0;
        pin_now     = 1'b0;
        pin_hit     = 1'b0;
        pin_status  = 1'b0;
        trie_clear();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_letter(DIRECTED[i].cmd, DIRECTED[i].ltr, DIRECTED[i].fin,
                        DIRECTED[i].pin, DIRECTED[i].hit, DIRECTED[i].status);

        // random words; inserts outpace the pool, so it runs dry along the way
        while (letters_sent < DIRECTED_ROWS + RANDOM_LETTERS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40 || vocab.size() == 0)
            begin
                if (vocab.size() > 0 && $urandom_range(0, 4) == 0)
                    w = vocab[$urandom_range(0, vocab.size() - 1)];
                else
                begin
                    w = draw_word(10);
                    if (vocab.size() >= 64)
                        vocab.delete($urandom_range(0, vocab.size() - 1));
                    vocab.push_back(w);
                end
                send_word(w, CMD_INSERT, 1'b0);
            end
            else if (pick < 65)
                send_word(vocab[$urandom_range(0, vocab.size() - 1)], CMD_SEARCH, 1'b0);
            else if (pick < 80)
            begin
                w     = vocab[$urandom_range(0, vocab.size() - 1)];
                w.len = 4'($urandom_range(1, w.len));
                send_word(w, ($urandom_range(0, 3) == 0) ? CMD_SPARE : CMD_PREFIX, 1'b0);
            end
            else if (pick < 90)
                send_word(draw_word(6), ($urandom_range(0, 1) == 0) ? CMD_SEARCH : CMD_PREFIX,
                          1'b0);
            else
                send_word(draw_word(MAX_WORD), CMD_INSERT, 1'b1);
        end
        in_valid <= 1'b0;

        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fails == 0 && answers_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
